@@ rtl/core/ccw_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// ccw_pkg: shared types, constants and microcode for the coin change counter
// Holds the denomination table, the control word layout and the program
// that the sequencer steps through.
// ---------------------------------------------------------------------------
package ccw_pkg;

	// sizes
	localparam int MAX_AMOUNT = 1023;
	localparam int AMT_W      = 10;
	localparam int ADDR_W     = $clog2(MAX_AMOUNT + 1);
	localparam int DEPTH      = MAX_AMOUNT + 1;
	localparam int COUNT_W    = 64;
	localparam int KINDS_W    = 4;
	localparam int NUM_DENOMS = 6;
	localparam int K_W        = 3;
	localparam int DENOM_W    = 6;
	localparam int PC_W       = 4;

	localparam logic [KINDS_W-1:0] KINDS_RESET = KINDS_W'(NUM_DENOMS);

	typedef logic [PC_W-1:0]    pc_t;
	typedef logic [DENOM_W-1:0] denom_t;

	// datapath actions, one per control word
	typedef enum logic [3:0] {
		ACT_NOP,
		ACT_LATCH,
		ACT_WR_ONE,
		ACT_WR_ZERO,
		ACT_K_CLR,
		ACT_A_COIN,
		ACT_RD_UPD,
		ACT_ADD_WR,
		ACT_K_INC,
		ACT_RD_RES,
		ACT_EMIT,
		ACT_EMIT_ERR
	} act_t;

	// jump conditions
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_START,
		C_BAD,
		C_A_LT_AMT,
		C_COIN_GT_AMT,
		C_K_NEXT_LT
	} cond_t;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		pc_t   target;
	} uword_t;

	// flags from the datapath to the sequencer
	typedef struct packed {
		logic bad;
		logic a_lt_amt;
		logic coin_gt_amt;
		logic k_next_lt;
	} dp_status_t;

	// program step addresses
	localparam pc_t PC_IDLE  = 4'd0;
	localparam pc_t PC_CHECK = 4'd1;
	localparam pc_t PC_ZERO  = 4'd2;
	localparam pc_t PC_KCLR  = 4'd3;
	localparam pc_t PC_PASS  = 4'd4;
	localparam pc_t PC_READ  = 4'd5;
	localparam pc_t PC_UPD   = 4'd6;
	localparam pc_t PC_NEXTK = 4'd7;
	localparam pc_t PC_FETCH = 4'd8;
	localparam pc_t PC_EMIT  = 4'd9;
	localparam pc_t PC_ERR   = 4'd10;
	localparam pc_t PC_LAST  = PC_ERR;

	// denomination list, smallest first
	function automatic denom_t denom(input logic [K_W-1:0] k);
		denom_t d;
		case (k)
			3'd0: d = 6'd1;
			3'd1: d = 6'd2;
			3'd2: d = 6'd3;
			3'd3: d = 6'd5;
			3'd4: d = 6'd10;
			3'd5: d = 6'd50;
			default: d = 6'd0;
		endcase
		return d;
	endfunction

	// microcode ROM: action, jump condition, jump target
	function automatic uword_t ucode_word(input pc_t pc);
		uword_t w;
		case (pc)
			PC_IDLE:  w = '{ACT_LATCH,    C_NO_START,    PC_IDLE};
			PC_CHECK: w = '{ACT_WR_ONE,   C_BAD,         PC_ERR};
			PC_ZERO:  w = '{ACT_WR_ZERO,  C_A_LT_AMT,    PC_ZERO};
			PC_KCLR:  w = '{ACT_K_CLR,    C_NEVER,       PC_IDLE};
			PC_PASS:  w = '{ACT_A_COIN,   C_COIN_GT_AMT, PC_NEXTK};
			PC_READ:  w = '{ACT_RD_UPD,   C_NEVER,       PC_IDLE};
			PC_UPD:   w = '{ACT_ADD_WR,   C_A_LT_AMT,    PC_READ};
			PC_NEXTK: w = '{ACT_K_INC,    C_K_NEXT_LT,   PC_PASS};
			PC_FETCH: w = '{ACT_RD_RES,   C_NEVER,       PC_IDLE};
			PC_EMIT:  w = '{ACT_EMIT,     C_ALWAYS,      PC_IDLE};
			PC_ERR:   w = '{ACT_EMIT_ERR, C_ALWAYS,      PC_IDLE};
			default:  w = '{ACT_NOP,      C_ALWAYS,      PC_IDLE};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/ccw_sequencer.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// ccw_sequencer: microcode step counter
// Fetches one control word per step from the program table and chooses the
// next step from the word's jump condition and the datapath flags.
// ---------------------------------------------------------------------------
module ccw_sequencer import ccw_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire dp_status_t status,
	output act_t            act,
	output logic            busy
);

	pc_t    pc_q;
	uword_t word;
	logic   take;

	// fetch the current control word
	assign word = ucode_word(pc_q);
	assign act  = word.act;
	assign busy = (pc_q != PC_IDLE);

	// evaluate the jump condition
	always_comb begin
		case (word.cond)
			C_NEVER:       take = 1'b0;
			C_ALWAYS:      take = 1'b1;
			C_NO_START:    take = !start;
			C_BAD:         take = status.bad;
			C_A_LT_AMT:    take = status.a_lt_amt;
			C_COIN_GT_AMT: take = status.coin_gt_amt;
			C_K_NEXT_LT:   take = status.k_next_lt;
			default:       take = 1'b0;
		endcase
	end

	// advance or jump
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else if (take) begin
			pc_q <= word.target;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_accept_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (pc_q == PC_CHECK))
		else $error("accepted transaction did not enter the check step");

	a_pc_in_program: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= PC_LAST)
		else $error("step counter left the program");
`endif

endmodule
`default_nettype wire

@@ rtl/core/ccw_datapath.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// ccw_datapath: ways table, saturating adder and result registers
// Executes the action of the current control word: table writes, reads,
// counter updates and the result strobe.
// ---------------------------------------------------------------------------
module ccw_datapath import ccw_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire act_t               act,
	input  wire logic [AMT_W-1:0]   target_amount,
	input  wire logic               cfg_we,
	input  wire logic [KINDS_W-1:0] cfg_data,
	output dp_status_t              status,
	output logic                    done,
	output logic [COUNT_W-1:0]      way_count,
	output logic                    bad_request,
	output logic                    count_saturated
);

	logic [COUNT_W-1:0] ways_mem [DEPTH];

	logic [KINDS_W-1:0] kinds_cfg_q;
	logic [KINDS_W-1:0] kinds_q;
	logic [AMT_W-1:0]   amount_q;
	logic [AMT_W-1:0]   a_q;
	logic [K_W-1:0]     k_q;
	logic               clamp_q;
	logic [COUNT_W-1:0] rd0_q;
	logic [COUNT_W-1:0] rd1_q;
	logic               done_q;
	logic [COUNT_W-1:0] count_q;
	logic               bad_q;
	logic               sat_q;

	denom_t             coin;
	logic [AMT_W-1:0]   coin_ext;
	logic [AMT_W-1:0]   raddr0;
	logic [AMT_W-1:0]   raddr1;
	logic [COUNT_W:0]   sum;
	logic [COUNT_W-1:0] sum_sat;
	logic               mem_we;
	logic [AMT_W-1:0]   waddr;
	logic [COUNT_W-1:0] wdata;

	assign coin     = denom(k_q);
	assign coin_ext = AMT_W'(coin);

	// status flags for the jump conditions
	assign status.bad = (amount_q == '0) || (kinds_q == '0)
		|| (kinds_q > KINDS_W'(NUM_DENOMS))
		|| (32'(amount_q) > 32'(MAX_AMOUNT));
	assign status.a_lt_amt    = (a_q < amount_q);
	assign status.coin_gt_amt = (coin_ext > amount_q);
	assign status.k_next_lt   = ((KINDS_W'(k_q) + 1'b1) < kinds_q);

	// saturating add of the two table reads
	assign sum     = {1'b0, rd0_q} + {1'b0, rd1_q};
	assign sum_sat = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];

	// read addresses: current amount and amount less coin, or the result
	assign raddr0 = (act == ACT_RD_RES) ? amount_q : a_q;
	assign raddr1 = a_q - coin_ext;

	// table write port
	always_comb begin
		mem_we = 1'b0;
		waddr  = a_q;
		wdata  = sum_sat;
		case (act)
			ACT_WR_ONE: begin
				mem_we = 1'b1;
				waddr  = '0;
				wdata  = COUNT_W'(1);
			end
			ACT_WR_ZERO: begin
				mem_we = 1'b1;
				wdata  = '0;
			end
			ACT_ADD_WR: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// ways table: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ways_mem[ADDR_W'(waddr)] <= wdata;
		end
		rd0_q <= ways_mem[ADDR_W'(raddr0)];
		rd1_q <= ways_mem[ADDR_W'(raddr1)];
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kinds_cfg_q <= KINDS_RESET;
		end else if (cfg_we) begin
			kinds_cfg_q <= cfg_data;
		end
	end

	// working registers of one transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamp_q <= 1'b0;
			k_q     <= '0;
			a_q     <= '0;
		end else begin
			case (act)
				ACT_LATCH:   clamp_q <= 1'b0;
				ACT_WR_ONE:  a_q <= AMT_W'(1);
				ACT_WR_ZERO: a_q <= a_q + 1'b1;
				ACT_K_CLR:   k_q <= '0;
				ACT_A_COIN:  a_q <= coin_ext;
				ACT_ADD_WR: begin
					a_q     <= a_q + 1'b1;
					clamp_q <= clamp_q | sum[COUNT_W];
				end
				ACT_K_INC:   k_q <= k_q + 1'b1;
				default: begin
					a_q <= a_q;
				end
			endcase
		end
	end

	// hold the request while idle
	always_ff @(posedge clk) begin
		if (act == ACT_LATCH) begin
			amount_q <= target_amount;
			kinds_q  <= kinds_cfg_q;
		end
	end

	// result strobe, one cycle per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (act == ACT_EMIT) || (act == ACT_EMIT_ERR);
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (act == ACT_EMIT) begin
			count_q <= rd0_q;
			bad_q   <= 1'b0;
			sat_q   <= clamp_q;
		end else if (act == ACT_EMIT_ERR) begin
			count_q <= '0;
			bad_q   <= 1'b1;
			sat_q   <= 1'b0;
		end
	end

	assign done            = done_q;
	assign way_count       = count_q;
	assign bad_request     = bad_q;
	assign count_saturated = sat_q;

`ifndef SYNTHESIS
	a_lower_addr_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(act == ACT_ADD_WR) |-> (a_q >= coin_ext))
		else $error("table update reads below amount zero");

	a_error_result_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && bad_q) |-> ((count_q == '0) && !sat_q))
		else $error("error result carries a count or saturation flag");

	a_clamp_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(clamp_q && (act != ACT_LATCH)) |=> clamp_q)
		else $error("saturation flag dropped within a transaction");
`endif

endmodule
`default_nettype wire

@@ rtl/core/coin_change_way_counter.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// coin_change_way_counter: counts the ways to make an amount from coins
// Bottom-up table over the amounts, driven by a microcoded sequencer.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: raise start with target_amount; the transaction is
//   taken at a rising edge where start is high and busy is low. busy stays
//   high while the table is worked.
//   Result channel: done pulses for one cycle with way_count, bad_request
//   and count_saturated. The receiver cannot stall; the result is taken in
//   that cycle. done rises at the same edge as busy falls, and a new command
//   may be taken in that same cycle.
//   Configuration: cfg_data is written to coin_kinds_used when cfg_valid is
//   high; cfg_ready is always high. Write only while idle.
// Sequence: a valid request sets table entry 0 to one and clears entries 1
//   to A (A = amount), then for each coin kind in use runs a pass over the
//   amounts from that coin up to A, skipped when the coin exceeds A. Each
//   table update is a registered read of the table, then an add and write.
//   An improper request goes from the check step to the error result.
// Reset: coin_kinds_used returns to 6 and the sequencer goes idle; the table
//   is not cleared, since every entry is written before it is read.
// ---------------------------------------------------------------------------
module coin_change_way_counter import ccw_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [AMT_W-1:0]   target_amount,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [KINDS_W-1:0] cfg_data,
	output logic                    done,
	output logic [COUNT_W-1:0]      way_count,
	output logic                    bad_request,
	output logic                    count_saturated
);

	act_t       act;
	dp_status_t status;

	// configuration is always accepted
	assign cfg_ready = 1'b1;

	// control program
	ccw_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.act    (act),
		.busy   (busy)
	);

	// table and arithmetic
	ccw_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.act             (act),
		.target_amount   (target_amount),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_data        (cfg_data),
		.status          (status),
		.done            (done),
		.way_count       (way_count),
		.bad_request     (bad_request),
		.count_saturated (count_saturated)
	);

endmodule
`default_nettype wire

@@ verif/coin_way_checker.sv @@
// ---------------------------------------------------------------------------
// coin_way_checker: result predictor and comparator for the coin way counter
// Watches the command, configuration and result channels of the block. Each
// accepted command is turned into an expected result by an independent
// bottom-up count over the amounts. Each result strobe is compared field by
// field against the oldest expectation held in order.
// ---------------------------------------------------------------------------
module coin_way_checker import ccw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [AMT_W-1:0]   target_amount,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [KINDS_W-1:0] cfg_data,
	input  logic               done,
	input  logic [COUNT_W-1:0] way_count,
	input  logic               bad_request,
	input  logic               count_saturated,
	output int                 fail_count,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               bad;
		logic               sat;
	} way_result_t;

	localparam int COIN_VALUES [NUM_DENOMS] = '{1, 2, 3, 5, 10, 50};

	way_result_t        expected_ways_q [$];
	logic [KINDS_W-1:0] kinds_now;
	int                 mismatches;

	// Count the coin combinations for one amount, clamping every addition
	function automatic way_result_t count_coin_ways(input logic [AMT_W-1:0] amount,
			input logic [KINDS_W-1:0] kinds);
		logic [COUNT_W-1:0] ways [0:MAX_AMOUNT];
		logic [COUNT_W:0]   sum;
		way_result_t        r;
		int                 amt;
		int                 coin;
		r = '0;
		amt = int'(amount);
		if (amt == 0 || kinds < 1 || kinds > NUM_DENOMS || amt > MAX_AMOUNT) begin
			r.bad = 1'b1;
			return r;
		end
		ways[0] = COUNT_W'(1);
		for (int a = 1; a <= amt; a++)
			ways[a] = '0;
		for (int k = 0; k < int'(kinds); k++) begin
			coin = COIN_VALUES[k];
			for (int a = coin; a <= amt; a++) begin
				sum = {1'b0, ways[a]} + {1'b0, ways[a - coin]};
				if (sum[COUNT_W]) begin
					ways[a] = '1;
					r.sat = 1'b1;
				end else begin
					ways[a] = sum[COUNT_W-1:0];
				end
			end
		end
		r.count = ways[amt];
		return r;
	endfunction

	// Compare results, predict accepted commands, then track the register
	always @(posedge clk or negedge arst_n) begin
		way_result_t exp_r;
		if (!arst_n) begin
			expected_ways_q.delete();
			kinds_now = KINDS_RESET;
			mismatches = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (done) begin
				if (expected_ways_q.size() == 0) begin
					$display("%0t: unexpected result: count %0d bad %0b sat %0b",
						$time, way_count, bad_request, count_saturated);
					mismatches++;
				end else begin
					exp_r = expected_ways_q.pop_front();
					if (way_count !== exp_r.count) begin
						$display("%0t: way_count expected %0d actual %0d",
							$time, exp_r.count, way_count);
						mismatches++;
					end
					if (bad_request !== exp_r.bad) begin
						$display("%0t: bad_request expected %0b actual %0b",
							$time, exp_r.bad, bad_request);
						mismatches++;
					end
					if (count_saturated !== exp_r.sat) begin
						$display("%0t: count_saturated expected %0b actual %0b",
							$time, exp_r.sat, count_saturated);
						mismatches++;
					end
				end
			end
			if (start && !busy)
				expected_ways_q.push_back(count_coin_ways(target_amount, kinds_now));
			if (cfg_valid && cfg_ready)
				kinds_now = cfg_data;
			fail_count <= mismatches;
			pending <= expected_ways_q.size();
		end
	end

endmodule

@@ verif/coin_change_way_counter_tb.sv @@
// ---------------------------------------------------------------------------
// coin_change_way_counter_tb: stimulus and verdict for the coin way counter
// Runs a directed set of amounts and coin kind settings, then random phases
// that each write the coin kind register and issue a batch of commands, all
// but one with random gaps; a checker predicts and compares every result.
// ---------------------------------------------------------------------------
module coin_change_way_counter_tb import ccw_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 8_000_000;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 13;
	localparam int NUM_DIRECTED = 13;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [AMT_W-1:0]   target_amount;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [KINDS_W-1:0] cfg_data;
	logic               done;
	logic [COUNT_W-1:0] way_count;
	logic               bad_request;
	logic               count_saturated;
	int                 fail_count;
	int                 pending;
	int                 cycle_count;
	bit                 gaps_on;
	logic [AMT_W-1:0]   directed_amounts [NUM_DIRECTED];

	coin_change_way_counter dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.target_amount   (target_amount),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.done            (done),
		.way_count       (way_count),
		.bad_request     (bad_request),
		.count_saturated (count_saturated)
	);

	coin_way_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.target_amount   (target_amount),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.done            (done),
		.way_count       (way_count),
		.bad_request     (bad_request),
		.count_saturated (count_saturated),
		.fail_count      (fail_count),
		.pending         (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Abort a run that hangs
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// Issue one command transaction, holding start until it is taken
	task automatic send_amount(input logic [AMT_W-1:0] amount);
		while (gaps_on && $urandom_range(0, 99) < 12) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		target_amount <= amount;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Drop start, wait for every result, then write the coin kind register
	task automatic set_coin_kinds(input logic [KINDS_W-1:0] kinds);
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		cfg_valid <= 1'b1;
		cfg_data <= kinds;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Mostly small amounts to keep the run short, some wide ones for every bit
	function automatic logic [AMT_W-1:0] pick_amount();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return AMT_W'($urandom_range(1, 63));
		else if (r < 75)
			return '0;
		else if (r < 95)
			return AMT_W'($urandom_range(64, MAX_AMOUNT));
		return AMT_W'(MAX_AMOUNT);
	endfunction

	// Mostly legal coin kind settings, with the illegal ones mixed in
	function automatic logic [KINDS_W-1:0] pick_kinds();
		if ($urandom_range(0, 99) < 70)
			return KINDS_W'($urandom_range(1, NUM_DENOMS));
		return KINDS_W'($urandom_range(0, 15));
	endfunction

	initial begin
		directed_amounts = '{10'd0, 10'd1, 10'd2, 10'd3, 10'd4, 10'd5, 10'd10,
			10'd50, 10'd51, 10'd100, 10'd341, 10'd682, 10'd1023};
		arst_n <= 1'b0;
		start <= 1'b0;
		target_amount <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		gaps_on = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset setting of all six coins, then each special setting
		foreach (directed_amounts[i])
			send_amount(directed_amounts[i]);
		set_coin_kinds(4'd0);
		send_amount(10'd5);
		set_coin_kinds(4'd15);
		send_amount(10'd1023);
		set_coin_kinds(4'd7);
		send_amount(10'd3);
		set_coin_kinds(4'd1);
		send_amount(10'd1023);
		send_amount(10'd2);
		set_coin_kinds(4'd2);
		send_amount(10'd4);
		set_coin_kinds(4'd3);
		send_amount(10'd6);
		set_coin_kinds(4'd4);
		send_amount(10'd1);
		set_coin_kinds(4'd5);
		send_amount(10'd60);

		// Random phases, one of them without idle cycles
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			gaps_on = (p != 2);
			set_coin_kinds(pick_kinds());
			repeat (PHASE_ITEMS)
				send_amount(pick_amount());
		end

		// Drain outstanding results, then give the verdict
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/ccw_pkg.sv
rtl/core/ccw_sequencer.sv
rtl/core/ccw_datapath.sv
rtl/core/coin_change_way_counter.sv
verif/coin_way_checker.sv
verif/coin_change_way_counter_tb.sv
